/* rtl/msek_pkg.sv */
// Shared types, constants and saturating helpers for the minimal surface element kernel.
`timescale 1ns / 1ps
`default_nettype none
package msek_pkg;

	typedef struct packed {
		logic signed [31:0] vertex_a_x;
		logic signed [31:0] vertex_a_y;
		logic signed [31:0] vertex_b_x;
		logic signed [31:0] vertex_b_y;
		logic signed [31:0] vertex_c_x;
		logic signed [31:0] vertex_c_y;
		logic signed [31:0] u_vertex_a;
		logic signed [31:0] u_vertex_b;
		logic signed [31:0] u_vertex_c;
	} msek_elem_t;

	typedef struct packed {
		logic [1:0]         row_index;
		logic signed [47:0] entry_col0;
		logic signed [47:0] entry_col1;
		logic signed [47:0] entry_col2;
		logic signed [47:0] rhs_entry;
		logic               degenerate;
		logic               last_row;
	} msek_row_t;

	localparam logic signed [63:0] LIM     = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] ONE_Q32 = 64'sh0000_0001_0000_0000;
	localparam logic signed [63:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] OUT_MIN = -64'sh0000_8000_0000_0000;

	localparam int MUL_LAT   = 3;
	localparam int DIV_STEPS = 2;
	localparam int DIV_STG   = 64 / DIV_STEPS;
	localparam int DIV_LAT   = 1 + DIV_STG;
	localparam int ISQ_BITS  = 32;
	localparam int ISQ_LAT   = ISQ_BITS;

	localparam int FRAC_GU    = 35;
	localparam int FRAC_GPHI  = 58;
	localparam int FRAC_S     = 32;
	localparam int AREA_SHIFT = 21;

	localparam logic [1:0] ROW_FIRST = 2'd0;
	localparam logic [1:0] ROW_LAST  = 2'd2;

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		logic [63:0] r;
		r = v[63] ? (~v + 64'd1) : v;
		return r;
	endfunction

	function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		logic signed [63:0] r;
		s = 65'(a) + 65'(b);
		if (s > 65'(LIM))
			r = LIM;
		else if (s < -65'(LIM))
			r = -LIM;
		else
			r = s[63:0];
		return r;
	endfunction

	function automatic logic signed [47:0] to_out48(input logic signed [63:0] v);
		logic signed [63:0] r;
		if (v > OUT_MAX)
			r = OUT_MAX;
		else if (v < OUT_MIN)
			r = OUT_MIN;
		else
			r = v;
		return r[47:0];
	endfunction

endpackage
`default_nettype wire

/* rtl/msek_dly.sv */
// Enabled shift line that delays a word; it moves only while en is high.
`timescale 1ns / 1ps
`default_nettype none
module msek_dly #(
	parameter int W = 64,
	parameter int N = 1
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic [W-1:0]      q
);

	logic [W-1:0] sr_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			sr_q[0] <= d;
			for (int i = 1; i < N; i++)
				sr_q[i] <= sr_q[i-1];
		end
	end

	assign q = sr_q[N-1];

endmodule
`default_nettype wire

/* rtl/msek_mul.sv */
// Three-stage saturating Q.32 multiplier built from four 32x32 partial products.
`timescale 1ns / 1ps
`default_nettype none
module msek_mul
	import msek_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [63:0] a,
	input  wire logic signed [63:0] b,
	output logic signed [63:0]      p
);

	logic [63:0]  am_s1, bm_s1;
	logic         neg_s1;
	logic [63:0]  pp0_s2, pp1_s2, pp2_s2, pp3_s2;
	logic         neg_s2;
	logic signed [63:0] p_s3;
	logic [127:0] full;
	logic         sat;
	logic [63:0]  m;

	always_comb begin
		full = {64'd0, pp0_s2} + {32'd0, pp1_s2, 32'd0} + {32'd0, pp2_s2, 32'd0}
			+ {pp3_s2, 64'd0};
		sat = |full[127:95];
		m = sat ? LIM : full[95:32];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			am_s1  <= mag64(a);
			bm_s1  <= mag64(b);
			neg_s1 <= a[63] ^ b[63];
			pp0_s2 <= am_s1[31:0] * bm_s1[31:0];
			pp1_s2 <= am_s1[31:0] * bm_s1[63:32];
			pp2_s2 <= am_s1[63:32] * bm_s1[31:0];
			pp3_s2 <= am_s1[63:32] * bm_s1[63:32];
			neg_s2 <= neg_s1;
			p_s3   <= neg_s2 ? -$signed(m) : $signed(m);
		end
	end

	assign p = p_s3;

endmodule
`default_nettype wire

/* rtl/msek_div.sv */
// Pipelined restoring divider giving a saturated signed quotient with F fraction bits.
`timescale 1ns / 1ps
`default_nettype none
module msek_div
	import msek_pkg::*;
#(
	parameter int F = 32
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [63:0] n,
	input  wire logic [63:0]        dm,
	input  wire logic               dneg,
	output logic signed [63:0]      q
);

	logic [127:0] nm;
	logic [63:0]  r_s   [DIV_STG+1];
	logic [63:0]  w_s   [DIV_STG+1];
	logic [63:0]  d_s   [DIV_STG];
	logic         ovf_s [DIV_STG+1];
	logic         neg_s [DIV_STG+1];
	logic [63:0]  res;

	assign nm = 128'(mag64(n)) << F;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]   <= nm[127:64];
			w_s[0]   <= nm[63:0];
			d_s[0]   <= dm;
			ovf_s[0] <= nm[127:64] >= dm;
			neg_s[0] <= n[63] ^ dneg;
		end
	end

	for (genvar k = 0; k < DIV_STG; k++) begin : g_stg
		logic [63:0] r_c, w_c;
		logic [64:0] t_c;

		always_comb begin
			r_c = r_s[k];
			w_c = w_s[k];
			t_c = '0;
			for (int j = 0; j < DIV_STEPS; j++) begin
				t_c = {r_c, w_c[63]};
				w_c = {w_c[62:0], 1'b0};
				if (t_c >= {1'b0, d_s[k]}) begin
					t_c    = t_c - {1'b0, d_s[k]};
					w_c[0] = 1'b1;
				end
				r_c = t_c[63:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k+1]   <= r_c;
				w_s[k+1]   <= w_c;
				ovf_s[k+1] <= ovf_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end

		if (k < DIV_STG - 1) begin : g_dcarry
			always_ff @(posedge clk) begin
				if (en)
					d_s[k+1] <= d_s[k];
			end
		end
	end

	assign res = (ovf_s[DIV_STG] | w_s[DIV_STG][63]) ? LIM : w_s[DIV_STG];
	assign q   = neg_s[DIV_STG] ? -$signed(res) : $signed(res);

endmodule
`default_nettype wire

/* rtl/msek_isqrt.sv */
// Bit-per-stage inverse square root: largest Q0.32 c with c*c*t not above one, or one if t <= 1.
`timescale 1ns / 1ps
`default_nettype none
module msek_isqrt
	import msek_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [63:0] t,
	output logic signed [63:0]      c
);

	localparam logic [127:0] PLIM = 128'd1 << 96;

	logic [63:0]  ut_s [ISQ_BITS-1];
	logic [127:0] p_s  [ISQ_BITS-1];
	logic [127:0] r_s  [ISQ_BITS-1];
	logic [31:0]  c_s  [ISQ_BITS];
	logic         le_s [ISQ_BITS];

	for (genvar k = 0; k < ISQ_BITS; k++) begin : g_stg
		localparam int BIT = ISQ_BITS - 1 - k;
		logic [63:0]  ut_i;
		logic [127:0] p_i, r_i, pn;
		logic [31:0]  c_i;
		logic         le_i, take;

		if (k == 0) begin : g_first
			assign ut_i = t;
			assign p_i  = '0;
			assign r_i  = '0;
			assign c_i  = '0;
			assign le_i = t <= ONE_Q32;
		end else begin : g_next
			assign ut_i = ut_s[k-1];
			assign p_i  = p_s[k-1];
			assign r_i  = r_s[k-1];
			assign c_i  = c_s[k-1];
			assign le_i = le_s[k-1];
		end

		always_comb begin
			pn   = p_i + (r_i << (BIT + 1)) + ({64'd0, ut_i} << (2 * BIT));
			take = pn <= PLIM;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				c_s[k]  <= take ? (c_i | (32'd1 << BIT)) : c_i;
				le_s[k] <= le_i;
			end
		end

		if (k < ISQ_BITS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					ut_s[k] <= ut_i;
					p_s[k]  <= take ? pn : p_i;
					r_s[k]  <= take ? (r_i + ({64'd0, ut_i} << BIT)) : r_i;
				end
			end
		end
	end

	assign c = le_s[ISQ_BITS-1] ? ONE_Q32 : $signed({32'd0, c_s[ISQ_BITS-1]});

endmodule
`default_nettype wire

/* rtl/p1_minimal_surface_element_kernel.sv */
// Top level of the P1 triangle Newton Jacobian kernel for the minimal surface equation.
//
// An element item enters on the elem channel (valid/ready): three vertices in Q4.28 and
// the solution at each vertex in Q8.24. For every element three row items leave on the
// row channel (valid/ready), rows 0, 1 and 2 in order, the third marked by last_row.
// Each row holds three Jacobian entries and the right-hand side entry in Q16.32.
// A zero doubled area sets degenerate and forces all entries of that element to zero.
// Once an accepted element has passed the pipeline its first row is offered; the next
// two rows follow on consecutive cycles while the receiver takes them.
// The row channel carries three rows per element, so under a stream of elements the
// pipeline moves only as each last row is taken; it takes an element whenever it moves.
// The 82 stages are the front-end products, 33-stage dividers, the sum register, the
// 32-stage inverse square root, four rounds of three-stage multipliers, output register.
// When the receiver stalls, the whole pipeline holds and elem_ready falls; nothing is
// lost or repeated. Reset empties the pipeline and offers no rows.
`timescale 1ns / 1ps
`default_nettype none
module p1_minimal_surface_element_kernel
	import msek_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       elem_valid,
	output logic            elem_ready,
	input  wire msek_elem_t elem,
	output logic            row_valid,
	input  wire logic       row_ready,
	output msek_row_t       row
);

	localparam int T_E     = DIV_LAT + MUL_LAT + 1;
	localparam int T_B     = T_E + ISQ_LAT;
	localparam int T_P     = T_B + 3 * MUL_LAT;
	localparam int VLD_LEN = 3 + T_P;

	localparam int PI [6]   = '{0, 0, 0, 1, 1, 2};
	localparam int PJ [6]   = '{0, 1, 2, 1, 2, 2};
	localparam int SIDX [9] = '{0, 1, 2, 1, 3, 4, 2, 4, 5};

	logic en;

	// Front end: floored coordinates, edges, differences of u
	logic signed [29:0] pax, pay, pbx, pby, pcx, pcy;
	logic signed [32:0] dbw, dcw;
	logic signed [30:0] ex_s1 [3], ey_s1 [3];
	logic signed [31:0] db_s1, dc_s1;

	logic signed [61:0] pd1_s2, pd2_s2;
	logic signed [62:0] gxa_s2, gxb_s2, gya_s2, gyb_s2;
	logic signed [61:0] eex_s2 [6], eey_s2 [6];
	logic signed [30:0] ex_s2 [3], ey_s2 [3];

	logic signed [63:0] d_s3, gxn_s3, gyn_s3;
	logic signed [63:0] ee_s3 [6];
	logic signed [30:0] ex_s3 [3], ey_s3 [3];

	logic [63:0] dmag;
	logic [63:0] area;
	logic        degen;

	assign pax = elem.vertex_a_x[31:2];
	assign pay = elem.vertex_a_y[31:2];
	assign pbx = elem.vertex_b_x[31:2];
	assign pby = elem.vertex_b_y[31:2];
	assign pcx = elem.vertex_c_x[31:2];
	assign pcy = elem.vertex_c_y[31:2];
	assign dbw = 33'(elem.u_vertex_b) - 33'(elem.u_vertex_a);
	assign dcw = 33'(elem.u_vertex_c) - 33'(elem.u_vertex_a);

	always_ff @(posedge clk) begin
		if (en) begin
			ex_s1[0] <= 31'(pcx) - 31'(pbx);
			ey_s1[0] <= 31'(pcy) - 31'(pby);
			ex_s1[1] <= 31'(pax) - 31'(pcx);
			ey_s1[1] <= 31'(pay) - 31'(pcy);
			ex_s1[2] <= 31'(pbx) - 31'(pax);
			ey_s1[2] <= 31'(pby) - 31'(pay);
			db_s1    <= dbw[32:1];
			dc_s1    <= dcw[32:1];

			pd1_s2 <= ey_s1[2] * ex_s1[1];
			pd2_s2 <= ex_s1[2] * ey_s1[1];
			gxa_s2 <= db_s1 * ey_s1[1];
			gxb_s2 <= dc_s1 * ey_s1[2];
			gya_s2 <= db_s1 * ex_s1[1];
			gyb_s2 <= dc_s1 * ex_s1[2];
			for (int k = 0; k < 6; k++) begin
				eex_s2[k] <= ex_s1[PI[k]] * ex_s1[PJ[k]];
				eey_s2[k] <= ey_s1[PI[k]] * ey_s1[PJ[k]];
			end
			ex_s2 <= ex_s1;
			ey_s2 <= ey_s1;

			d_s3   <= 64'(pd1_s2) - 64'(pd2_s2);
			gxn_s3 <= 64'(gxa_s2) + 64'(gxb_s2);
			gyn_s3 <= -(64'(gya_s2) + 64'(gyb_s2));
			for (int k = 0; k < 6; k++)
				ee_s3[k] <= 64'(eex_s2[k]) + 64'(eey_s2[k]);
			ex_s3 <= ex_s2;
			ey_s3 <= ey_s2;
		end
	end

	assign dmag  = mag64(d_s3);
	assign area  = dmag >> AREA_SHIFT;
	assign degen = d_s3 == '0;

	// Dividers
	logic signed [63:0] gx, gy;
	logic signed [63:0] gpx [3], gpy [3];
	logic signed [63:0] s [6];

	msek_div #(.F(FRAC_GU)) u_div_gx (
		.clk(clk), .en(en), .n(gxn_s3), .dm(dmag), .dneg(d_s3[63]), .q(gx));
	msek_div #(.F(FRAC_GU)) u_div_gy (
		.clk(clk), .en(en), .n(gyn_s3), .dm(dmag), .dneg(d_s3[63]), .q(gy));

	for (genvar i = 0; i < 3; i++) begin : g_gphi
		msek_div #(.F(FRAC_GPHI)) u_div_x (
			.clk(clk), .en(en), .n(64'(ey_s3[i])), .dm(dmag), .dneg(d_s3[63]),
			.q(gpx[i]));
		msek_div #(.F(FRAC_GPHI)) u_div_y (
			.clk(clk), .en(en), .n(-64'(ex_s3[i])), .dm(dmag), .dneg(d_s3[63]),
			.q(gpy[i]));
	end

	for (genvar k = 0; k < 6; k++) begin : g_sdiv
		msek_div #(.F(FRAC_S)) u_div_s (
			.clk(clk), .en(en), .n(ee_s3[k]), .dm(dmag << 1), .dneg(1'b0), .q(s[k]));
	end

	// |grad u|^2 and q_i
	logic signed [63:0] gxx, gyy, qx [3], qy [3];
	logic signed [63:0] t_s40, q_s40 [3];

	msek_mul u_mul_gxx (.clk(clk), .en(en), .a(gx), .b(gx), .p(gxx));
	msek_mul u_mul_gyy (.clk(clk), .en(en), .a(gy), .b(gy), .p(gyy));
	for (genvar i = 0; i < 3; i++) begin : g_qmul
		msek_mul u_mul_x (.clk(clk), .en(en), .a(gx), .b(gpx[i]), .p(qx[i]));
		msek_mul u_mul_y (.clk(clk), .en(en), .a(gy), .b(gpy[i]), .p(qy[i]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s40 <= sadd64(ONE_Q32, sadd64(gxx, gyy));
			for (int i = 0; i < 3; i++)
				q_s40[i] <= sadd64(qx[i], qy[i]);
		end
	end

	// c, c^3 and the products
	logic [63:0]        area_d;
	logic signed [63:0] c, c_m, c_2m, cc, c3;
	logic signed [63:0] v [3], v_b [3], v_2 [3], q_b [3];
	logic signed [63:0] w [9], w_d [9], c3w [9];
	logic signed [63:0] s_d [6], cs [6], cv [3];
	logic               degen_d;

	msek_dly #(.W(64), .N(T_E)) u_dly_area (.clk(clk), .en(en), .d(area), .q(area_d));
	msek_dly #(.W(1), .N(T_P)) u_dly_degen (.clk(clk), .en(en), .d(degen), .q(degen_d));

	msek_isqrt u_isqrt (.clk(clk), .en(en), .t(t_s40), .c(c));

	msek_mul u_mul_cc (.clk(clk), .en(en), .a(c), .b(c), .p(cc));
	msek_dly #(.W(64), .N(MUL_LAT)) u_dly_c1 (.clk(clk), .en(en), .d(c), .q(c_m));
	msek_dly #(.W(64), .N(MUL_LAT)) u_dly_c2 (.clk(clk), .en(en), .d(c_m), .q(c_2m));
	msek_mul u_mul_c3 (.clk(clk), .en(en), .a(cc), .b(c_m), .p(c3));

	for (genvar i = 0; i < 3; i++) begin : g_row
		msek_mul u_mul_v (.clk(clk), .en(en), .a(q_s40[i]), .b($signed(area_d)), .p(v[i]));
		msek_dly #(.W(64), .N(ISQ_LAT)) u_dly_q (
			.clk(clk), .en(en), .d(q_s40[i]), .q(q_b[i]));
		msek_dly #(.W(64), .N(ISQ_LAT - MUL_LAT)) u_dly_v (
			.clk(clk), .en(en), .d(v[i]), .q(v_b[i]));
		msek_dly #(.W(64), .N(2 * MUL_LAT)) u_dly_v2 (
			.clk(clk), .en(en), .d(v_b[i]), .q(v_2[i]));
		msek_mul u_mul_cv (.clk(clk), .en(en), .a(c_2m), .b(v_2[i]), .p(cv[i]));
	end

	for (genvar k = 0; k < 9; k++) begin : g_ent
		msek_mul u_mul_w (.clk(clk), .en(en), .a(q_b[k / 3]), .b(v_b[k % 3]), .p(w[k]));
		msek_dly #(.W(64), .N(MUL_LAT)) u_dly_w (.clk(clk), .en(en), .d(w[k]), .q(w_d[k]));
		msek_mul u_mul_c3w (.clk(clk), .en(en), .a(c3), .b(w_d[k]), .p(c3w[k]));
	end

	for (genvar k = 0; k < 6; k++) begin : g_sent
		msek_dly #(.W(64), .N(T_B + 2 * MUL_LAT - DIV_LAT)) u_dly_s (
			.clk(clk), .en(en), .d(s[k]), .q(s_d[k]));
		msek_mul u_mul_cs (.clk(clk), .en(en), .a(c_2m), .b(s_d[k]), .p(cs[k]));
	end

	// Output stage and row sequencing
	logic [VLD_LEN-1:0] vld_q;
	logic               vld_s82;
	logic signed [47:0] jent_s82 [9];
	logic signed [47:0] rhs_s82 [3];
	logic               degen_s82;
	logic [1:0]         row_q;

	assign en         = !vld_s82 || (row_ready && row_q == ROW_LAST);
	assign elem_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld_s82 <= 1'b0;
			row_q   <= ROW_FIRST;
		end else begin
			if (en) begin
				vld_q   <= {vld_q[VLD_LEN-2:0], elem_valid};
				vld_s82 <= vld_q[VLD_LEN-1];
			end
			if (vld_s82 && row_ready)
				row_q <= (row_q == ROW_LAST) ? ROW_FIRST : row_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			degen_s82 <= degen_d;
			for (int k = 0; k < 9; k++)
				jent_s82[k] <= degen_d ? '0 : to_out48(sadd64(cs[SIDX[k]], c3w[k]));
			for (int i = 0; i < 3; i++)
				rhs_s82[i] <= degen_d ? '0 : to_out48(-cv[i]);
		end
	end

	always_comb begin
		row.row_index  = row_q;
		row.degenerate = degen_s82;
		row.last_row   = row_q == ROW_LAST;
		case (row_q)
			2'd0: begin
				row.entry_col0 = jent_s82[0];
				row.entry_col1 = jent_s82[1];
				row.entry_col2 = jent_s82[2];
				row.rhs_entry  = rhs_s82[0];
			end
			2'd1: begin
				row.entry_col0 = jent_s82[3];
				row.entry_col1 = jent_s82[4];
				row.entry_col2 = jent_s82[5];
				row.rhs_entry  = rhs_s82[1];
			end
			default: begin
				row.entry_col0 = jent_s82[6];
				row.entry_col1 = jent_s82[7];
				row.entry_col2 = jent_s82[8];
				row.rhs_entry  = rhs_s82[2];
			end
		endcase
	end

	assign row_valid = vld_s82;

`ifndef ASSERT_OFF
	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && row_ready && row.last_row |=> row_q == ROW_FIRST)
		else $error("row counter did not return to the first row");

	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && row_ready && !row.last_row |=> row_valid && row_q == $past(row_q) + 2'd1)
		else $error("row counter did not step within an element");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && row.degenerate |-> row.entry_col0 == '0 && row.entry_col1 == '0
			&& row.entry_col2 == '0 && row.rhs_entry == '0)
		else $error("degenerate element carries nonzero entries");
`endif

endmodule
`default_nettype wire
